// File: hdl/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg
// Shared constants, codes and inter-module structs for the selective-repeat
// receive reorder window.
// ----------------------------------------------------------------------------
package arq_pkg;

  localparam int RING_DEPTH  = 64;
  localparam int SEQ_BITS    = $clog2(RING_DEPTH);
  localparam int HANDLE_BITS = 32;
  localparam int WIN_BITS    = 6;
  localparam logic [WIN_BITS-1:0] WINDOW_SIZE_INIT = WIN_BITS'(32);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result status codes; also used as the command kind in the queue.
  typedef enum logic [1:0] {
    ST_DROP    = 2'd0,
    ST_HOLD    = 2'd1,
    ST_DELIVER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SEND
  } back_state_t;

  typedef struct packed {
    status_t               kind;
    logic [SEQ_BITS-1:0]   seq;
  } q_entry_t;

  // Window state seen by the classifier.
  typedef struct packed {
    logic [RING_DEPTH-1:0] marked;
    logic [SEQ_BITS-1:0]   base;
  } slot_view_t;

  // Store of an accepted frame into its slot.
  typedef struct packed {
    logic                   valid;
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
  } store_req_t;

endpackage

// File: hdl/arq_front.sv
// ----------------------------------------------------------------------------
// arq_front
// Accepts frames, classifies each as drop, hold or in-order fill, issues the
// slot store and queues a command for the back end.
// ----------------------------------------------------------------------------
module arq_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arq_pkg::SEQ_BITS-1:0]    frame_seq,
  input  logic [arq_pkg::HANDLE_BITS-1:0] frame_handle,
  input  logic [arq_pkg::WIN_BITS-1:0]    win,
  input  arq_pkg::slot_view_t           view,
  input  logic                          drain_done,
  input  logic                          q_full,
  output logic                          push,
  output arq_pkg::q_entry_t             push_entry,
  output arq_pkg::store_req_t           store
);
  import arq_pkg::*;

  logic                busy;
  logic [SEQ_BITS-1:0] offset;
  logic                drop;
  logic                fills_base;

  // busy: an in-order fill is queued or draining; base and marks will move
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (push && push_entry.kind == ST_DELIVER) begin
      busy <= 1'b1;
    end else if (drain_done) begin
      busy <= 1'b0;
    end
  end

  always_comb begin
    offset     = frame_seq - view.base;
    drop       = view.marked[frame_seq] || (WIN_BITS'(offset) >= win);
    fills_base = (frame_seq == view.base);

    in_ready = !busy && !q_full;
    push     = in_valid && in_ready;

    push_entry.seq = frame_seq;
    if (drop) begin
      push_entry.kind = ST_DROP;
    end else if (fills_base) begin
      push_entry.kind = ST_DELIVER;
    end else begin
      push_entry.kind = ST_HOLD;
    end

    store.valid  = push && !drop;
    store.seq    = frame_seq;
    store.handle = frame_handle;
  end

endmodule

// File: hdl/arq_fifo.sv
// ----------------------------------------------------------------------------
// arq_fifo
// Short command queue between the classifier and the delivery engine.
// ----------------------------------------------------------------------------
module arq_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arq_pkg::q_entry_t push_entry,
  input  logic              pop,
  output arq_pkg::q_entry_t head,
  output logic              empty,
  output logic              full
);
  import arq_pkg::*;

  q_entry_t             entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (count == '0);
  assign full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/arq_back.sv
// ----------------------------------------------------------------------------
// arq_back
// Owns the window state (base, slot marks, handle memory), executes queued
// commands and drives the output register. A drain walks the marked run from
// the base, one slot per read/send pair.
// ----------------------------------------------------------------------------
module arq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [arq_pkg::WIN_BITS-1:0]    win,
  input  arq_pkg::store_req_t             store,
  output arq_pkg::slot_view_t             view,
  input  arq_pkg::q_entry_t               q_head,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            drain_done,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [arq_pkg::SEQ_BITS-1:0]    out_seq,
  output logic [arq_pkg::HANDLE_BITS-1:0] out_handle,
  output logic                            last
);
  import arq_pkg::*;

  back_state_t            state;
  back_state_t            state_next;
  logic [SEQ_BITS-1:0]    base;
  logic [RING_DEPTH-1:0]  marked;
  logic [WIN_BITS-1:0]    n;
  logic [HANDLE_BITS-1:0] mem [RING_DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;
  logic [SEQ_BITS-1:0]    pend_seq;
  logic                   pend_last;

  logic                   out_free;
  logic                   do_read;
  logic                   load_out;
  logic                   start_drain;
  status_t                ld_status;
  logic [SEQ_BITS-1:0]    ld_seq;
  logic [HANDLE_BITS-1:0] ld_handle;
  logic                   ld_last;
  logic [WIN_BITS-1:0]    n_inc;
  logic [SEQ_BITS-1:0]    base_inc;
  logic                   run_ends;

  assign view.marked = marked;
  assign view.base   = base;

  assign n_inc    = n + 1'b1;
  assign base_inc = base + 1'b1;
  // stop at the window width or at the first gap
  assign run_ends = (n_inc >= win) || !marked[base_inc];

  always_comb begin
    out_free    = !out_valid || out_ready;
    state_next  = state;
    pop         = 1'b0;
    do_read     = 1'b0;
    load_out    = 1'b0;
    start_drain = 1'b0;
    drain_done  = 1'b0;
    ld_status   = ST_DROP;
    ld_seq      = q_head.seq;
    ld_handle   = '0;
    ld_last     = 1'b1;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          if (q_head.kind == ST_DELIVER) begin
            start_drain = 1'b1;
            state_next  = B_READ;
          end else begin
            load_out  = 1'b1;
            ld_status = q_head.kind;
          end
        end
      end
      B_READ: begin
        do_read    = 1'b1;
        state_next = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = ST_DELIVER;
          ld_seq    = pend_seq;
          ld_handle = rd_data;
          ld_last   = pend_last;
          if (pend_last) begin
            drain_done = 1'b1;
            state_next = B_IDLE;
          end else begin
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // handle memory: one write port (store), one registered read port (drain)
  always_ff @(posedge clk) begin
    if (store.valid) begin
      mem[store.seq] <= store.handle;
    end
    if (do_read) begin
      rd_data <= mem[base];
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      pend_seq  <= base;
      pend_last <= run_ends;
    end
    if (load_out) begin
      status     <= ld_status;
      out_seq    <= ld_seq;
      out_handle <= ld_handle;
      last       <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      base      <= '0;
      marked    <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_drain) begin
        n <= '0;
      end else if (do_read) begin
        n <= n_inc;
      end
      if (do_read) begin
        base         <= base_inc;
        marked[base] <= 1'b0;
      end
      if (store.valid) begin
        marked[store.seq] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_read_marked: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ) |-> marked[base])
    else $error("drain reads an unmarked slot");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == B_SEND) |-> (n != '0) && (n <= win))
    else $error("drain ran past the window width");

  a_no_store_in_drain: assert property (@(posedge clk) disable iff (rst)
    store.valid |-> (state != B_READ) && (state != B_SEND))
    else $error("slot store during drain");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> (state == B_IDLE))
    else $error("drain end did not return to idle");

endmodule

// File: hdl/arq_receive_reorder_window.sv
// ----------------------------------------------------------------------------
// arq_receive_reorder_window
// Selective-repeat receive window over a 64-slot sequence ring. Frames are
// dropped, held, or, when they fill the base slot, release the marked run
// from the base in sequence order.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+----------------------------------
//   frame    | in  | in_valid / in_ready   | frame_seq, frame_handle
//   result   | out | out_valid / out_ready | status, out_seq, out_handle, last
//   config   | in  | cfg_write_en          | cfg_write_data (window_size)
//
// Flow: a drop or hold item is classified in its accept cycle, queued, and
// loaded into the output register when it reaches the queue head and the
// output is free. An in-order fill pops its command, then per slot reads
// the handle memory's registered read port and loads the output.
// While a fill is queued or draining, the front holds in_ready low.
// Reset (synchronous, active high) clears the base, every slot mark, the
// queue and the output valid; window_size returns to 32. Handle memory is not
// cleared. Output stalls back up into the queue, then into in_ready.
// ----------------------------------------------------------------------------
module arq_receive_reorder_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [arq_pkg::SEQ_BITS-1:0]    frame_seq,
  input  logic [arq_pkg::HANDLE_BITS-1:0] frame_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [arq_pkg::SEQ_BITS-1:0]    out_seq,
  output logic [arq_pkg::HANDLE_BITS-1:0] out_handle,
  output logic                            last,
  input  logic                            cfg_write_en,
  input  logic [arq_pkg::WIN_BITS-1:0]    cfg_write_data
);
  import arq_pkg::*;

  // window width; its full 6-bit range already stays below the ring depth
  logic [WIN_BITS-1:0] window_size;

  slot_view_t view;
  store_req_t store;
  q_entry_t   push_entry;
  q_entry_t   q_head;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  logic       drain_done;

  // hold the window width; the user must write it only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_INIT;
    end else if (cfg_write_en) begin
      window_size <= cfg_write_data;
    end
  end

  // front: classify against base and marks, store the slot, queue a command
  arq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_seq    (frame_seq),
    .frame_handle (frame_handle),
    .win          (window_size),
    .view         (view),
    .drain_done   (drain_done),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry),
    .store        (store)
  );

  // queue: decouple classification from delivery
  arq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // back: report drops and holds, drain in-order runs, advance the base
  arq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .win        (window_size),
    .store      (store),
    .view       (view),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .pop        (pop),
    .drain_done (drain_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .out_seq    (out_seq),
    .out_handle (out_handle),
    .last       (last)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the selective-repeat receive window. A planner
// fills a queue of frames: a short directed opening, then bursts of in-window
// frames in shuffled order mixed with stray and repeated frames, over several
// window widths. A clocked driver offers the frames with random gaps, and a
// clocked receiver applies random back-pressure plus one long hold-off. The
// monitor mirrors the window state on every accepted frame and compares each
// released result field by field against the oldest one it predicted.
// ----------------------------------------------------------------------------
module tb;
  import arq_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no item on either channel
  localparam int CHOKE_CYCLES = 400;  // long receiver hold-off

  // Window state: width, oldest undelivered sequence, slot marks and handles.
  typedef struct packed {
    logic [WIN_BITS-1:0]                    width;
    logic [SEQ_BITS-1:0]                    base;
    logic [RING_DEPTH-1:0]                  marked;
    logic [RING_DEPTH-1:0][HANDLE_BITS-1:0] handles;
  } window_t;

  typedef struct packed {
    status_t                kind;
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
    logic                   last;
  } release_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0]    seq;
    logic [HANDLE_BITS-1:0] handle;
  } frame_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SEQ_BITS-1:0]    frame_seq = '0;
  logic [HANDLE_BITS-1:0] frame_handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [SEQ_BITS-1:0]    out_seq;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   last;
  logic                   cfg_write_en = 1'b0;
  logic [WIN_BITS-1:0]    cfg_write_data = '0;

  frame_t   frames_to_send[$];
  release_t results_due[$];
  window_t  window_mirror;  // follows the frames the block has taken
  window_t  plan_window;    // follows the frames queued by the planner
  frame_t   next_frame;
  release_t want;

  int  frames_planned = 0;
  int  frames_taken = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  choke_left = 0;
  bit  frame_taken = 1'b0;
  bit  send_idle_on = 1'b0;
  bit  recv_idle_on = 1'b0;
  bit  choke_req = 1'b0;
  bit  choke_ack = 1'b0;

  arq_receive_reorder_window dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .frame_seq     (frame_seq),
    .frame_handle  (frame_handle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_seq       (out_seq),
    .out_handle    (out_handle),
    .last          (last),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one frame to a window state. With record set, queue the results
  // that the block must release for it.
  function automatic void window_accept(inout window_t w,
                                        input logic [SEQ_BITS-1:0] seq,
                                        input logic [HANDLE_BITS-1:0] handle,
                                        input bit record);
    logic [SEQ_BITS-1:0] offset;
    logic [SEQ_BITS-1:0] cur;
    release_t            r;
    int                  n;
    offset   = seq - w.base;
    r.seq    = seq;
    r.handle = '0;
    r.last   = 1'b1;
    // Drop a repeat of a held frame, or anything outside [base, base+width).
    if (w.marked[seq] || offset >= w.width) begin
      r.kind = ST_DROP;
      if (record) results_due.push_back(r);
      return;
    end
    w.handles[seq] = handle;
    w.marked[seq]  = 1'b1;
    if (seq != w.base) begin
      r.kind = ST_HOLD;
      if (record) results_due.push_back(r);
      return;
    end
    // Filled the base slot: release the marked run, at most one window width.
    cur = w.base;
    n   = 0;
    while (n < w.width && w.marked[cur]) begin
      r.kind        = ST_DELIVER;
      r.seq         = cur;
      r.handle      = w.handles[cur];
      w.marked[cur] = 1'b0;
      cur           = cur + 1'b1;
      n++;
      r.last        = (n >= w.width) || !w.marked[cur];
      if (record) results_due.push_back(r);
    end
    w.base = cur;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  task automatic offer(input logic [SEQ_BITS-1:0] seq, input logic [HANDLE_BITS-1:0] handle);
    frame_t f;
    f.seq    = seq;
    f.handle = handle;
    frames_to_send.push_back(f);
    frames_planned++;
    window_accept(plan_window, seq, handle, 1'b0);
  endtask

  // Hold until every planned item is taken and every result has come back.
  task automatic wait_idle();
    while (frames_taken != frames_planned || results_due.size() != 0) @(negedge clk);
  endtask

  // Write the window width while the block is idle.
  task automatic set_window(input logic [WIN_BITS-1:0] width);
    wait_idle();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= width;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    plan_window = window_mirror;
  endtask

  // Fill every unmarked slot up to the highest marked one, base slot last,
  // so the window ends empty and a later width change cannot strand a slot.
  task automatic close_gaps();
    logic [SEQ_BITS-1:0] slot;
    int                  top;
    int                  d;
    top = -1;
    for (d = 0; d < RING_DEPTH; d++) begin
      slot = SEQ_BITS'(plan_window.base + d);
      if (plan_window.marked[slot]) top = d;
    end
    if (top > 0) begin
      for (d = top; d >= 0; d--) begin
        slot = SEQ_BITS'(plan_window.base + d);
        if (!plan_window.marked[slot]) offer(slot, $urandom());
      end
    end
  endtask

  // Shuffled in-window bursts from the current base, with stray frames and
  // repeats mixed in.
  task automatic plan_random(input int n_items);
    int                  order[RING_DEPTH];
    int                  done;
    int                  k;
    int                  j;
    int                  pick;
    int                  cap;
    int                  tmp;
    logic [SEQ_BITS-1:0] burst_base;
    logic [SEQ_BITS-1:0] slot;
    done = 0;
    while (done < n_items) begin
      if (plan_window.width == 0 || $urandom_range(0, 9) < 2) begin
        offer(SEQ_BITS'($urandom()), $urandom());
        done++;
      end else begin
        cap = (plan_window.width < 6) ? int'(plan_window.width) : 6;
        if ($urandom_range(0, 9) == 0) k = $urandom_range(1, plan_window.width);
        else k = $urandom_range(1, cap);
        for (j = 0; j < k; j++) order[j] = j;
        for (j = k - 1; j > 0; j--) begin
          pick        = $urandom_range(0, j);
          tmp         = order[j];
          order[j]    = order[pick];
          order[pick] = tmp;
        end
        burst_base = plan_window.base;
        for (j = 0; j < k; j++) begin
          slot = SEQ_BITS'(burst_base + order[j]);
          offer(slot, $urandom());
          done++;
          // Resend now and then: a duplicate while held, stale once released.
          if ($urandom_range(0, 9) == 0) begin
            offer(slot, $urandom());
            done++;
          end
        end
      end
    end
    close_gaps();
  endtask

  // Stimulus: reset, then phases separated by width writes at idle.
  initial begin
    logic [SEQ_BITS-1:0] b;
    int                  d;
    window_mirror       = '0;
    window_mirror.width = WINDOW_SIZE_INIT;
    plan_window         = window_mirror;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening at the reset width of 32, base 0.
    offer(6'd0, 32'hFFFF_FFFF);   // fills the base: delivered at once
    offer(6'd2, 32'h0000_0000);   // ahead of the base: held
    offer(6'd2, 32'hAAAA_AAAA);   // same slot again: duplicate, dropped
    offer(6'd33, 32'h5555_5555);  // one past the window top: dropped
    offer(6'd32, 32'h1234_5678);  // top slot of the window: held
    offer(6'd63, 32'hFFFF_FFFF);  // behind the base: dropped
    offer(6'd1, 32'h5555_5555);   // fills the base: releases 1 and 2

    // Widest window; the slot held at 32 gets released inside this phase.
    set_window(6'd63);
    send_idle_on <= 1'b1;
    recv_idle_on <= 1'b1;
    plan_random(110);

    // Narrowest nonzero window: only the base slot is accepted.
    set_window(6'd1);
    send_idle_on <= 1'b0;
    plan_random(50);

    // Zero width: every item is dropped.
    set_window(6'd0);
    for (d = 0; d < 6; d++) offer(SEQ_BITS'($urandom()), $urandom());

    // Choke the receiver while items keep coming, so the input stalls.
    set_window(6'd17);
    send_idle_on <= 1'b1;
    recv_idle_on <= 1'b1;
    plan_random(110);
    choke_req <= ~choke_req;

    // Full rate on both sides.
    set_window(6'd63);
    send_idle_on <= 1'b0;
    recv_idle_on <= 1'b0;
    plan_random(100);

    set_window(6'd5);
    send_idle_on <= 1'b1;
    recv_idle_on <= 1'b1;
    plan_random(60);

    // Narrow the window over held slots: the far one stays marked, counts as
    // a duplicate, and goes out once the base catches up with it.
    set_window(6'd32);
    b = plan_window.base;
    offer(SEQ_BITS'(b + 10), $urandom());
    for (d = 1; d <= 3; d++) offer(SEQ_BITS'(b + d), $urandom());
    set_window(6'd4);
    offer(SEQ_BITS'(b + 10), $urandom());
    offer(b, $urandom());
    for (d = 4; d <= 9; d++) offer(SEQ_BITS'(b + d), $urandom());

    // Release capped at one window width. The slot left marked at the new
    // base can never be refilled, so this stays at the end of the run.
    set_window(6'd32);
    b = plan_window.base;
    for (d = 1; d <= 6; d++) offer(SEQ_BITS'(b + d), $urandom());
    set_window(6'd3);
    offer(b, $urandom());
    offer(SEQ_BITS'(b + 3), $urandom());
    offer(SEQ_BITS'(b + 4), $urandom());

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Sender: present the next item once the current one is taken, after gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || frame_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (frames_to_send.size() > 0) begin
        next_frame    = frames_to_send.pop_front();
        in_valid     <= 1'b1;
        frame_seq    <= next_frame.seq;
        frame_handle <= next_frame.handle;
        send_gap     <= send_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      recv_gap   <= 0;
      choke_left <= 0;
    end else if (choke_req != choke_ack) begin
      choke_ack  <= choke_req;
      choke_left <= CHOKE_CYCLES;
      out_ready  <= 1'b0;
    end else if (choke_left > 0) begin
      choke_left <= choke_left - 1;
      out_ready  <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap  <= recv_idle_on ? pick_gap() : 0;
    end
  end

  // Monitor: mirror the window on each taken item, check each released one.
  always @(posedge clk) begin
    frame_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_write_en) window_mirror.width = cfg_write_data;
      if (in_valid && in_ready) begin
        window_accept(window_mirror, frame_seq, frame_handle, 1'b1);
        frames_taken++;
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d seq %0d handle %h last %0d",
                     status, out_seq, out_handle, last);
        end else begin
          want = results_due.pop_front();
          if (status !== want.kind || out_seq !== want.seq ||
              out_handle !== want.handle || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: want status %0d seq %0d handle %h last %0d,",
                        " got %0d %0d %h %0d"},
                       want.kind, want.seq, want.handle, want.last,
                       status, out_seq, out_handle, last);
          end
        end
      end
    end
    // Watchdog: end the run if neither channel moves for too long.
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// File: files.f
hdl/arq_pkg.sv
hdl/arq_front.sv
hdl/arq_fifo.sv
hdl/arq_back.sv
hdl/arq_receive_reorder_window.sv
test/tb.sv
